// ===== design/tkf_pkg.sv =====
// Shared types and constants for the tilt Kalman filter.
// No dependencies; tkf_serial_arith and tilt_kalman_filter import this package.
package tkf_pkg;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam int ATAN_LEN = 24;
    localparam logic [31:0] ATAN_DEG_Q24 [ATAN_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    // configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP     = 2'd0;
    localparam logic [1:0] CFG_PROCESS_NOISE = 2'd1;
    localparam logic [1:0] CFG_MEASURE_NOISE = 2'd2;

    localparam logic [16:0] TIME_STEP_RST     = 17'd6554;
    localparam logic [31:0] PROCESS_NOISE_RST = 32'd6554;
    localparam logic [31:0] MEASURE_NOISE_RST = 32'd262144;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TILT  = 8'b0000_0010,
        S_TRND  = 8'b0000_0100,
        S_ISSUE = 8'b0000_1000,
        S_WAIT  = 8'b0001_0000,
        S_PREP  = 8'b0010_0000,
        S_SUM   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_RUN  = 3'b010,
        U_FIN  = 3'b100
    } unit_state_t;

    // update program; codes are consecutive, the sequencer steps by one
    typedef enum logic [3:0] {
        OP_DT_BIAS = 4'd0,
        OP_DT_RATE = 4'd1,
        OP_DT_BB   = 4'd2,
        OP_DT_BA   = 4'd3,
        OP_DT_P01  = 4'd4,
        OP_K0      = 4'd5,
        OP_K1      = 4'd6,
        OP_K0_EPS  = 4'd7,
        OP_K1_EPS  = 4'd8,
        OP_KS0     = 4'd9,
        OP_KS1     = 4'd10,
        OP_CAA     = 4'd11,
        OP_CAB     = 4'd12,
        OP_CBA     = 4'd13,
        OP_CBB     = 4'd14
    } op_t;

    typedef struct packed {
        logic start;
        logic div;
    } arith_req_t;

endpackage

// ===== design/tkf_serial_arith.sv =====
// Bit-serial fixed point multiply (round half away) and divide (truncate),
// both saturating. Depends on tkf_pkg.
module tkf_serial_arith #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tkf_pkg::arith_req_t           req,
    input  logic signed [WORD_BITS-1:0]   op_a,
    input  logic signed [WORD_BITS-1:0]   op_b,
    output logic                          done,
    output logic signed [WORD_BITS-1:0]   result
);
    import tkf_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int NB  = WORD_BITS + FRAC_BITS;
    localparam int CNW = $clog2(NB + 1);
    localparam int MW  = 2 * WORD_BITS + 2;
    localparam int PW  = 2 * WORD_BITS + 1;

    function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [MW-1:0] m);
        logic signed [W-1:0] v;
        if (|(m >> (W - 1))) begin
            v = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            v = neg ? -$signed(m[W-1:0]) : $signed(m[W-1:0]);
        end
        return v;
    endfunction

    unit_state_t ust_reg, ust_next;
    logic              div_reg, neg_reg, zero_reg, ovf_reg, done_reg;
    logic [CNW-1:0]    cnt_reg;
    logic [W-1:0]      dvs_reg, rem_reg, q_reg;
    logic [NB-1:0]     sh_reg;
    logic [2*W-1:0]    acc_reg;
    logic signed [W-1:0] result_reg, fin_val;

    logic [W-1:0]   mag_a, mag_b;
    logic [W:0]     sum, rem_sh, rem_new;
    logic           ge;
    logic [PW-1:0]  prod_r;

    assign mag_a = op_a[W-1] ? -op_a : op_a;
    assign mag_b = op_b[W-1] ? -op_b : op_b;

    assign sum     = {1'b0, acc_reg[2*W-1:W]} + (sh_reg[0] ? {1'b0, dvs_reg} : '0);
    assign rem_sh  = {rem_reg, sh_reg[NB-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_new = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
    assign prod_r  = PW'(acc_reg) + (PW'(1) << (FRAC_BITS - 1));

    always_comb begin
        if (div_reg) begin
            fin_val = zero_reg ? '0 : from_mag(neg_reg, MW'({ovf_reg, q_reg}));
        end else begin
            fin_val = from_mag(neg_reg, MW'(prod_r >> FRAC_BITS));
        end
    end

    always_comb begin
        ust_next = ust_reg;
        unique case (ust_reg)
            U_IDLE: if (req.start) ust_next = U_RUN;
            U_RUN:  if (cnt_reg == CNW'(1)) ust_next = U_FIN;
            U_FIN:  ust_next = U_IDLE;
            default: ust_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ust_reg  <= U_IDLE;
            done_reg <= 1'b0;
        end else begin
            ust_reg  <= ust_next;
            done_reg <= (ust_reg == U_FIN);
        end
    end

    always_ff @(posedge aclk) begin
        if (ust_reg == U_IDLE && req.start) begin
            div_reg  <= req.div;
            neg_reg  <= op_a[W-1] ^ op_b[W-1];
            zero_reg <= (op_b == '0);
            ovf_reg  <= 1'b0;
            acc_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            if (req.div) begin
                cnt_reg <= CNW'(NB);
                dvs_reg <= mag_b;
                sh_reg  <= {mag_a, {FRAC_BITS{1'b0}}};
            end else begin
                cnt_reg <= CNW'(W);
                dvs_reg <= mag_a;
                sh_reg  <= NB'(mag_b);
            end
        end else if (ust_reg == U_RUN) begin
            cnt_reg <= cnt_reg - CNW'(1);
            if (div_reg) begin
                rem_reg <= rem_new[W-1:0];
                q_reg   <= {q_reg[W-2:0], ge};
                ovf_reg <= ovf_reg | q_reg[W-1];
                sh_reg  <= sh_reg << 1;
            end else begin
                acc_reg <= {sum, acc_reg[W-1:1]};
                sh_reg  <= sh_reg >> 1;
            end
        end else if (ust_reg == U_FIN) begin
            result_reg <= fin_val;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/tilt_kalman_filter.sv =====
// Two-state (angle, gyro bias) Kalman filter for one tilt axis.
// Depends on tkf_pkg and tkf_serial_arith.
//
// One transfer on the s_ channel is one command; each gives one result on the
// m_ channel. An init command runs the arctangent. An update command adds
// 13 multiplies and 2 divides on the shared bit-serial arithmetic unit, plus
// the sums in between. One command is processed at a time; the next is taken
// while a result is still waiting on m_ready. Configuration writes are always
// accepted.
module tilt_kalman_filter #(
    parameter int WORD_BITS  = 32,
    parameter int FRAC_BITS  = 16,
    parameter int ATAN_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [15:0] s_gyro_rate,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_angle_out,
    output logic signed [31:0] m_bias_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import tkf_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int SW   = ((WORD_BITS > 33) ? WORD_BITS : 33) + 2;
    localparam int MW   = 2 * WORD_BITS + 2;
    localparam int OWD  = (WORD_BITS > 32) ? WORD_BITS : 32;
    localparam int GW   = 26 + FRAC_BITS;
    localparam int CW   = 36;
    localparam int CZ   = 34;
    localparam int CZ1  = CZ + 1;
    localparam int TSH  = 24 - FRAC_BITS;
    localparam int TW   = $clog2(ATAN_STEPS);
    localparam logic [CZ:0] TRND = CZ1'((1 << TSH) >> 1);
    localparam logic signed [W-1:0] ONE_W = (FRAC_BITS >= WORD_BITS - 1) ?
        {1'b0, {(W-1){1'b1}}} : (W'(1) << FRAC_BITS);

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [W-1:0] r;
        if (&v[SW-1:W-1] || ~|v[SW-1:W-1]) begin
            r = v[W-1:0];
        end else begin
            r = v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        return sat_w(SW'(a) + SW'(b));
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        return sat_w(SW'(a) - SW'(b));
    endfunction

    function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [MW-1:0] m);
        logic signed [W-1:0] v;
        if (|(m >> (W - 1))) begin
            v = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            v = neg ? -$signed(m[W-1:0]) : $signed(m[W-1:0]);
        end
        return v;
    endfunction

    function automatic logic [31:0] to_out(input logic signed [W-1:0] v);
        logic signed [OWD-1:0] e;
        logic [31:0] r;
        e = OWD'(v);
        if (&e[OWD-1:31] || ~|e[OWD-1:31]) begin
            r = e[31:0];
        end else begin
            r = e[OWD-1] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg;

    logic [16:0] time_step_reg;
    logic [31:0] process_noise_reg, measure_noise_reg;

    logic signed [W-1:0] angle_reg, bias_reg, caa_reg, cab_reg, cba_reg, cbb_reg;
    logic signed [W-1:0] ap_reg, tmp_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [W-1:0] eps_reg, s_reg, k0_reg, k1_reg, ks0_reg, ks1_reg;
    logic signed [W-1:0] tilt_reg, u_reg;
    logic                cmd_reg, ay_zero_reg, ax_zero_reg, ax_neg_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [CZ-1:0] cz_reg;
    logic [TW-1:0]        tcnt_reg;
    logic                 m_valid_reg;
    logic [31:0]          angle_out_reg, bias_out_reg;

    // input conditioning
    logic signed [16:0] ax17, ay17, r17, axs17;
    logic [16:0]        aymag, rmag;
    logic [24:0]        g250;
    logic [GW-1:0]      gv;
    logic signed [W-1:0] u_in;

    assign ax17  = 17'(s_accel_x);
    assign ay17  = 17'(s_accel_y);
    assign r17   = 17'(s_gyro_rate);
    assign aymag = ay17[16] ? -ay17 : ay17;
    assign axs17 = ay17[16] ? -ax17 : ax17;
    assign rmag  = r17[16] ? -r17 : r17;
    assign g250  = 25'(rmag) * 25'd250;
    assign gv    = ((GW'(g250) << FRAC_BITS) + GW'(16384)) >> 15;
    assign u_in  = from_mag(r17[16], MW'(gv));

    // CORDIC step
    logic signed [CW-1:0] xs, ys;
    logic signed [CZ-1:0] tab;
    assign xs  = cx_reg >>> tcnt_reg;
    assign ys  = cy_reg >>> tcnt_reg;
    assign tab = $signed(CZ'(ATAN_DEG_Q24[5'(tcnt_reg)]));

    // angle rounding
    logic           zneg;
    logic [CZ-1:0]  zmag;
    logic [CZ:0]    zr;
    logic [MW-1:0]  tmag;
    logic           tneg;
    assign zneg = cz_reg[CZ-1];
    assign zmag = zneg ? -cz_reg : cz_reg;
    assign zr   = ({1'b0, zmag} + TRND) >> TSH;
    assign tmag = ay_zero_reg ? (ax_zero_reg ? '0 : (MW'(90) << FRAC_BITS)) : MW'(zr);
    assign tneg = ay_zero_reg ? ax_neg_reg : zneg;

    // arithmetic unit
    arith_req_t          req;
    logic signed [W-1:0] opa, opb, pr;
    logic signed [W-1:0] dtw;
    logic                pr_done;

    assign dtw = $signed(W'(time_step_reg));

    always_comb begin
        req.start = (state_reg == S_ISSUE);
        req.div   = 1'b0;
        opa = dtw;
        opb = bias_reg;
        unique case (op_reg)
            OP_DT_BIAS: opb = bias_reg;
            OP_DT_RATE: opb = u_reg;
            OP_DT_BB:   opb = cbb_reg;
            OP_DT_BA:   opb = cba_reg;
            OP_DT_P01:  opb = p01_reg;
            OP_K0:      begin opa = p00_reg; opb = s_reg; req.div = 1'b1; end
            OP_K1:      begin opa = p10_reg; opb = s_reg; req.div = 1'b1; end
            OP_K0_EPS:  begin opa = k0_reg;  opb = eps_reg; end
            OP_K1_EPS:  begin opa = k1_reg;  opb = eps_reg; end
            OP_KS0:     begin opa = k0_reg;  opb = s_reg;   end
            OP_KS1:     begin opa = k1_reg;  opb = s_reg;   end
            OP_CAA:     begin opa = ks0_reg; opb = k0_reg;  end
            OP_CAB:     begin opa = ks0_reg; opb = k1_reg;  end
            OP_CBA:     begin opa = ks1_reg; opb = k0_reg;  end
            OP_CBB:     begin opa = ks1_reg; opb = k1_reg;  end
            default:    begin opa = dtw;     opb = bias_reg; end
        endcase
    end

    tkf_serial_arith #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .op_a    (opa),
        .op_b    (opb),
        .done    (pr_done),
        .result  (pr)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_TILT;
            S_TILT:  if (tcnt_reg == TW'(ATAN_STEPS - 1)) state_next = S_TRND;
            S_TRND:  state_next = cmd_reg ? S_ISSUE : S_DONE;
            S_ISSUE: state_next = S_WAIT;
            S_WAIT: begin
                if (pr_done) begin
                    if (op_reg == OP_DT_P01)     state_next = S_PREP;
                    else if (op_reg == OP_CBB)   state_next = S_DONE;
                    else                         state_next = S_ISSUE;
                end
            end
            S_PREP:  state_next = S_SUM;
            S_SUM:   state_next = S_ISSUE;
            S_DONE:  if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            m_valid_reg       <= 1'b0;
            time_step_reg     <= TIME_STEP_RST;
            process_noise_reg <= PROCESS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
            angle_reg         <= '0;
            bias_reg          <= '0;
            caa_reg           <= ONE_W;
            cab_reg           <= '0;
            cba_reg           <= '0;
            cbb_reg           <= ONE_W;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_TIME_STEP:     time_step_reg     <= cfg_data[16:0];
                    CFG_PROCESS_NOISE: process_noise_reg <= cfg_data;
                    CFG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (state_reg == S_TRND && !cmd_reg) begin
                angle_reg <= from_mag(tneg, tmag);
                bias_reg  <= '0;
                caa_reg   <= ONE_W;
                cab_reg   <= '0;
                cba_reg   <= '0;
                cbb_reg   <= ONE_W;
            end else if (state_reg == S_WAIT && pr_done) begin
                unique case (op_reg)
                    OP_K0_EPS: angle_reg <= sat_add(ap_reg, pr);
                    OP_K1_EPS: bias_reg  <= sat_add(bias_reg, pr);
                    OP_CAA:    caa_reg   <= sat_sub(p00_reg, pr);
                    OP_CAB:    cab_reg   <= sat_sub(p01_reg, pr);
                    OP_CBA:    cba_reg   <= sat_sub(p10_reg, pr);
                    OP_CBB:    cbb_reg   <= sat_sub(p11_reg, pr);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_reg     <= s_command;
                    u_reg       <= u_in;
                    ay_zero_reg <= (s_accel_y == 16'sd0);
                    ax_zero_reg <= (s_accel_x == 16'sd0);
                    ax_neg_reg  <= s_accel_x[15];
                    cx_reg      <= CW'(aymag) << 16;
                    cy_reg      <= CW'(axs17) << 16;
                    cz_reg      <= '0;
                    tcnt_reg    <= '0;
                end
            end
            S_TILT: begin
                tcnt_reg <= tcnt_reg + TW'(1);
                if (!cy_reg[CW-1]) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + tab;
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - tab;
                end
            end
            S_TRND: begin
                tilt_reg <= from_mag(tneg, tmag);
                op_reg   <= OP_DT_BIAS;
            end
            S_WAIT: begin
                if (pr_done) begin
                    unique case (op_reg)
                        OP_DT_BIAS: tmp_reg <= sat_sub(angle_reg, pr);
                        OP_DT_RATE: ap_reg  <= sat_add(tmp_reg, pr);
                        OP_DT_BB: begin
                            p01_reg <= sat_sub(cab_reg, pr);
                            p10_reg <= sat_sub(cba_reg, pr);
                        end
                        OP_DT_BA:   tmp_reg <= sat_sub(caa_reg, pr);
                        OP_DT_P01:  tmp_reg <= sat_sub(tmp_reg, pr);
                        OP_K0:      k0_reg  <= pr;
                        OP_K1:      k1_reg  <= pr;
                        OP_KS0:     ks0_reg <= pr;
                        OP_KS1:     ks1_reg <= pr;
                        default: ;
                    endcase
                    if (op_reg == OP_DT_P01) begin
                        op_reg <= OP_K0;
                    end else if (op_reg != OP_CBB) begin
                        op_reg <= op_t'(op_reg + 4'd1);
                    end
                end
            end
            S_PREP: begin
                p00_reg <= sat_w(SW'(tmp_reg) + $signed(SW'(process_noise_reg)));
                p11_reg <= sat_w(SW'(cbb_reg) + $signed(SW'(process_noise_reg)));
                eps_reg <= sat_sub(tilt_reg, ap_reg);
            end
            S_SUM: begin
                s_reg <= sat_w(SW'(p00_reg) + $signed(SW'(measure_noise_reg)));
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    angle_out_reg <= to_out(angle_reg);
                    bias_out_reg  <= to_out(bias_reg);
                end
            end
            default: ;
        endcase
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_angle_out = $signed(angle_out_reg);
    assign m_bias_out  = $signed(bias_out_reg);

endmodule

// ===== design/tkf_checker.sv =====
// Port-level checks for tilt_kalman_filter, attached with a bind.
// Depends only on the top level's ports.
module tkf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_angle_out,
    input logic signed [31:0] m_bias_out
);

    // a stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_angle_out) && $stable(m_bias_out))
        else $error("result changed while stalled");

    // one command in flight: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // no result can appear the cycle after an input transfer
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind tilt_kalman_filter tkf_checker u_tkf_checker (.*);
